// ----- hw/rtl/i2ct_pkg.sv -----
// ----------------------------------------------------------------------------
// i2ct_pkg
// Shared types and codes for the I2C target with byte rings.
// ----------------------------------------------------------------------------
package i2ct_pkg;

	localparam logic [1:0] REQ_START    = 2'd0;
	localparam logic [1:0] REQ_OVERFLOW = 2'd1;
	localparam logic [1:0] REQ_PUSH     = 2'd2;
	localparam logic [1:0] REQ_POP      = 2'd3;

	typedef enum logic [3:0] {
		ACT_NONE     = 4'd0,
		ACT_IDLE     = 4'd1,
		ACT_ACK      = 4'd2,
		ACT_NACK     = 4'd3,
		ACT_SEND     = 4'd4,
		ACT_READ     = 4'd5,
		ACT_READ_ACK = 4'd6,
		ACT_ARM      = 4'd7,
		ACT_REWAIT   = 4'd8
	} action_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] bus_byte;
		logic       clock_still_high;
		logic [7:0] host_byte;
	} req_t;

	typedef struct packed {
		logic [3:0] line_action;
		logic [7:0] tx_byte;
		logic       push_accepted;
		logic [7:0] rx_byte;
		logic       rx_available;
		logic [2:0] bus_phase;
	} rsp_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic last;
	} ring_status_t;

endpackage

// ----- hw/rtl/i2ct_stream_if.sv -----
// ----------------------------------------------------------------------------
// i2ct_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface i2ct_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/i2ct_ring.sv -----
// ----------------------------------------------------------------------------
// i2ct_ring
// Byte ring buffer, one slot kept free; registered read data on pop.
// ----------------------------------------------------------------------------
module i2ct_ring
	import i2ct_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [7:0]   push_data,
	input  logic         pop,
	output ring_status_t status,
	output logic [7:0]   rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

	logic [7:0]    mem [DEPTH];
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [PW-1:0] head_nxt;
	logic [PW-1:0] tail_nxt;

	assign head_nxt = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;

	assign status.full  = (head_nxt == tail_q);
	assign status.empty = (head_q == tail_q);
	assign status.last  = (tail_nxt == head_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (push) begin
				head_q <= head_nxt;
			end
			if (pop) begin
				tail_q <= tail_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[head_q] <= push_data;
		end
		if (pop) begin
			rd_data <= mem[tail_q];
		end
	end

endmodule

// ----- hw/rtl/i2c_target_with_byte_fifos.sv -----
// ----------------------------------------------------------------------------
// i2c_target_with_byte_fifos
// Byte-level I2C target with receive and transmit byte rings.
// ----------------------------------------------------------------------------
// One request (bus event, host push or host pop) is taken per clock unless the
// response side stalls, and gives exactly one response: the protocol state and
// ring pointers update at the transfer edge, where the ring memory read is
// also registered, and the response register follows. A response register
// plus one stage of slack let the request side keep moving while a response
// waits. Each ring holds RING_DEPTH-1 bytes; a push to a full transmit ring is
// dropped and a pop from an empty receive ring returns 0.
module i2c_target_with_byte_fifos
	import i2ct_pkg::*;
#(
	parameter int RING_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_wdata,
	i2ct_stream_if.sink         req,
	i2ct_stream_if.source       rsp
);

	typedef enum logic [2:0] {
		PH_WAIT_START = 3'd0,
		PH_ADDRESS    = 3'd1,
		PH_DATA       = 3'd2,
		PH_SEND       = 3'd3,
		PH_SEND_ACK   = 3'd4,
		PH_WAIT_ACK   = 3'd5,
		PH_REQ_ACK    = 3'd6
	} phase_t;

	logic [6:0]   own_address_q;
	phase_t       phase_q;
	phase_t       phase_d;
	action_t      action;
	logic         send_next;
	logic         rx_push;
	logic         rx_pop;
	logic         tx_push;
	logic         tx_pop;
	logic         rx_avail;
	logic         fire;
	logic         advance;
	ring_status_t rx_st;
	ring_status_t tx_st;
	logic [7:0]   rx_rd;
	logic [7:0]   tx_rd;

	logic         valid_s1;
	action_t      action_s1;
	logic         send_s1;
	logic         pop_s1;
	logic         accepted_s1;
	logic         avail_s1;
	phase_t       phase_s1;

	logic         out_valid_q;
	rsp_t         out_q;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign fire      = req.valid && req.ready;

	always_comb begin
		phase_d   = phase_q;
		action    = ACT_NONE;
		send_next = 1'b0;
		rx_push   = 1'b0;
		rx_pop    = 1'b0;
		tx_push   = 1'b0;
		tx_pop    = 1'b0;
		unique case (req.payload.req_type)
			REQ_START: begin
				phase_d = PH_ADDRESS;
				action  = req.payload.clock_still_high ? ACT_REWAIT : ACT_ARM;
			end
			REQ_OVERFLOW: begin
				unique case (phase_q)
					PH_ADDRESS: begin
						if (req.payload.bus_byte == 8'd0 ||
						    req.payload.bus_byte[7:1] == own_address_q) begin
							phase_d = req.payload.bus_byte[0] ? PH_SEND : PH_SEND_ACK;
							action  = ACT_ACK;
						end else begin
							phase_d = PH_WAIT_START;
							action  = ACT_IDLE;
						end
					end
					PH_SEND_ACK: begin
						phase_d = PH_DATA;
						action  = ACT_READ;
					end
					PH_DATA: begin
						phase_d = PH_SEND_ACK;
						if (!rx_st.full) begin
							rx_push = 1'b1;
							action  = ACT_ACK;
						end else begin
							action = ACT_NACK;
						end
					end
					PH_WAIT_ACK: begin
						if (req.payload.bus_byte != 8'd0) begin
							action = ACT_IDLE;
						end else begin
							send_next = 1'b1;
						end
					end
					PH_SEND: begin
						send_next = 1'b1;
					end
					PH_REQ_ACK: begin
						phase_d = PH_WAIT_ACK;
						action  = ACT_READ_ACK;
					end
					default: begin
						phase_d = PH_WAIT_START;
						action  = ACT_IDLE;
					end
				endcase
				if (send_next) begin
					if (!tx_st.empty) begin
						tx_pop  = 1'b1;
						phase_d = PH_REQ_ACK;
						action  = ACT_SEND;
					end else begin
						phase_d = PH_WAIT_START;
						action  = ACT_IDLE;
					end
				end
			end
			REQ_PUSH: begin
				tx_push = !tx_st.full;
			end
			REQ_POP: begin
				rx_pop = !rx_st.empty;
			end
			default: begin
				action = ACT_NONE;
			end
		endcase
	end

	always_comb begin
		if (rx_push) begin
			rx_avail = 1'b1;
		end else if (rx_pop) begin
			rx_avail = !rx_st.last;
		end else begin
			rx_avail = !rx_st.empty;
		end
	end

	i2ct_ring #(
		.DEPTH(RING_DEPTH)
	) u_rx_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire && rx_push),
		.push_data(req.payload.bus_byte),
		.pop      (fire && rx_pop),
		.status   (rx_st),
		.rd_data  (rx_rd)
	);

	i2ct_ring #(
		.DEPTH(RING_DEPTH)
	) u_tx_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire && tx_push),
		.push_data(req.payload.host_byte),
		.pop      (fire && tx_pop),
		.status   (tx_st),
		.rd_data  (tx_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
			phase_q       <= PH_WAIT_START;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				own_address_q <= cfg_wdata;
			end
			if (fire) begin
				phase_q <= phase_d;
			end
			if (fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			action_s1   <= action;
			send_s1     <= tx_pop;
			pop_s1      <= rx_pop;
			accepted_s1 <= tx_push;
			avail_s1    <= rx_avail;
			phase_s1    <= phase_d;
		end
		if (advance) begin
			out_q.line_action   <= action_s1;
			out_q.tx_byte       <= send_s1 ? tx_rd : 8'd0;
			out_q.push_accepted <= accepted_s1;
			out_q.rx_byte       <= pop_s1 ? rx_rd : 8'd0;
			out_q.rx_available  <= avail_s1;
			out_q.bus_phase     <= phase_s1;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

endmodule

// ----- hw/rtl/i2ct_checker.sv -----
// ----------------------------------------------------------------------------
// i2ct_checker
// Port-level checks for the I2C target response channel.
// ----------------------------------------------------------------------------
module i2ct_checker
	import i2ct_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_payload
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("response changed while stalled");

	a_tx_only_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.tx_byte != 8'd0 |->
		rsp_payload.line_action == ACT_SEND)
		else $error("tx byte without send action");

	a_push_no_bus: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.push_accepted |->
		rsp_payload.line_action == ACT_NONE && rsp_payload.rx_byte == 8'd0)
		else $error("push response carries bus action or rx byte");

	a_pop_no_bus: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.rx_byte != 8'd0 |->
		rsp_payload.line_action == ACT_NONE && !rsp_payload.push_accepted)
		else $error("pop response carries bus action or push flag");

endmodule

bind i2c_target_with_byte_fifos i2ct_checker u_i2ct_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_payload(rsp.payload)
);
